@@ rtl/rpn_pkg.sv @@
// Package for the RPN stack calculator: opcodes, status codes, sequencer states.
// No dependencies.
package rpn_pkg;
  localparam int STACK_DEPTH_DEF = 128;

  typedef enum logic [2:0] {
    OP_NUMBER = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_EOL    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO_DIV = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    AU_ADD = 2'd0,
    AU_SUB = 2'd1,
    AU_MUL = 2'd2,
    AU_DIV = 2'd3
  } au_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_R,
    S_WT_R,
    S_GET_R,
    S_RD_L,
    S_WT_L,
    S_GET_L,
    S_CALC,
    S_WAIT_AU,
    S_PUSH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic   start;
    au_op_t op;
  } au_req_t;
endpackage

@@ rtl/rpn_stack_calculator_core.sv @@
// Top level of the RPN stack calculator: sequencer, stack memory, output register.
// Depends on rpn_pkg and rpn_arith.
// Usage: one token per item; the block takes an item only when idle and
// delivers one result per token. A push is a single stack write; add or subtract
// uses two registered stack reads plus a write, multiply runs 64 shift-add steps
// of the shared unit, and divide runs 96 restoring steps.
// The stack is a memory with separate read and write ports and registered read data.
module rpn_stack_calculator_core #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic signed [63:0] in_operand,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_result_value,
  output logic [2:0]         out_status,
  output logic [1:0]         out_empty_pops,
  output logic               out_line_done
);
  import rpn_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);

  logic [63:0] mem [STACK_DEPTH];
  logic [63:0] rd_q;

  state_t      state_r, state_nxt;
  logic [PW-1:0] sp_r, sp_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [63:0] rv_r, rv_nxt, lv_r, lv_nxt;
  logic [1:0]  emp_r, emp_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] o_val_r, o_val_nxt;
  logic [2:0]  o_st_r, o_st_nxt;
  logic [1:0]  o_emp_r, o_emp_nxt;
  logic        o_done_r, o_done_nxt;

  logic        we, re;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata;
  au_req_t     req;
  logic        au_done;
  logic [63:0] au_y;

  rpn_arith u_arith (.clk(clk), .rst_n(rst_n), .req(req), .a(lv_r), .b(rv_r),
                     .done(au_done), .y(au_y));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  always_comb begin
    state_nxt = state_r; sp_nxt = sp_r; op_nxt = op_r; rv_nxt = rv_r; lv_nxt = lv_r;
    emp_nxt = emp_r; ov_nxt = ov_r;
    o_val_nxt = o_val_r; o_st_nxt = o_st_r; o_emp_nxt = o_emp_r; o_done_nxt = o_done_r;
    we = 1'b0; re = 1'b0; waddr = sp_r[AW-1:0]; raddr = AW'(sp_r - PW'(1));
    wdata = in_operand; req = '{start: 1'b0, op: AU_ADD};
    in_stall = (state_r != S_IDLE) || ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !ov_r) begin
          op_nxt = in_op; emp_nxt = 2'd0;
          o_val_nxt = 64'd0; o_emp_nxt = 2'd0; o_done_nxt = 1'b0; o_st_nxt = ST_OK;
          if (in_op == OP_NUMBER) begin
            if (sp_r < FULL) begin
              we = 1'b1; sp_nxt = sp_r + PW'(1); o_val_nxt = in_operand;
            end else o_st_nxt = ST_FULL;
            ov_nxt = 1'b1;
          end else if (in_op >= OP_ADD && in_op <= OP_EOL) begin
            state_nxt = S_RD_R;
          end else begin
            o_st_nxt = ST_UNKNOWN; ov_nxt = 1'b1;
          end
        end
      end
      S_RD_R: begin
        if (sp_r != '0) begin
          re = 1'b1; sp_nxt = sp_r - PW'(1); state_nxt = S_WT_R;
        end else begin
          rv_nxt = 64'd0; emp_nxt = emp_r + 2'd1; state_nxt = S_GET_R;
        end
      end
      S_WT_R: begin rv_nxt = rd_q; state_nxt = S_GET_R; end
      S_GET_R: begin
        if (op_r == OP_EOL) begin
          o_val_nxt = rv_r; o_done_nxt = 1'b1; o_emp_nxt = emp_r;
          o_st_nxt = (emp_r != 2'd0) ? ST_EMPTY : ST_OK; state_nxt = S_OUT;
        end else if (op_r == OP_DIV && rv_r == 64'd0) begin
          o_st_nxt = ST_ZERO_DIV; o_emp_nxt = emp_r; state_nxt = S_OUT;
        end else state_nxt = S_RD_L;
      end
      S_RD_L: begin
        if (sp_r != '0) begin
          re = 1'b1; sp_nxt = sp_r - PW'(1); state_nxt = S_WT_L;
        end else begin
          lv_nxt = 64'd0; emp_nxt = emp_r + 2'd1; state_nxt = S_CALC;
        end
      end
      S_WT_L: begin lv_nxt = rd_q; state_nxt = S_CALC; end
      S_GET_L: state_nxt = S_CALC;
      S_CALC: begin
        req.start = 1'b1;
        case (op_r)
          OP_ADD:  req.op = AU_ADD;
          OP_SUB:  req.op = AU_SUB;
          OP_MUL:  req.op = AU_MUL;
          default: req.op = AU_DIV;
        endcase
        state_nxt = S_WAIT_AU;
      end
      S_WAIT_AU: if (au_done) state_nxt = S_PUSH;
      S_PUSH: begin
        o_emp_nxt = emp_r;
        wdata = au_y;
        if (sp_r < FULL) begin
          we = 1'b1; sp_nxt = sp_r + PW'(1); o_val_nxt = au_y;
          o_st_nxt = (emp_r != 2'd0) ? ST_EMPTY : ST_OK;
        end else o_st_nxt = ST_FULL;
        state_nxt = S_OUT;
      end
      S_OUT: begin ov_nxt = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; sp_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; sp_r <= sp_nxt; ov_r <= ov_nxt;
    end
    op_r <= op_nxt; rv_r <= rv_nxt; lv_r <= lv_nxt; emp_r <= emp_nxt;
    o_val_r <= o_val_nxt; o_st_r <= o_st_nxt; o_emp_r <= o_emp_nxt; o_done_r <= o_done_nxt;
  end

  assign out_valid = ov_r;
  assign out_result_value = o_val_r;
  assign out_status = o_st_r;
  assign out_empty_pops = o_emp_r;
  assign out_line_done = o_done_r;

`ifndef SYNTH
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= FULL) else $error("stack pointer overflow");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("ready while busy");
  a_no_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> state_r == S_IDLE) else $error("result while busy");
  a_done_eol: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && o_done_r |-> op_r == OP_EOL) else $error("line_done off eol");
`endif
endmodule

@@ rtl/rpn_arith.sv @@
// Shared iterative arithmetic unit: saturating add/sub, shift-add multiply,
// restoring divide, all Q32.32. Depends on rpn_pkg.
module rpn_arith (
  input  logic                clk,
  input  logic                rst_n,
  input  rpn_pkg::au_req_t    req,
  input  logic signed [63:0]  a,
  input  logic signed [63:0]  b,
  output logic                done,
  output logic signed [63:0]  y
);
  import rpn_pkg::*;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

  logic         busy_r, busy_nxt;
  au_op_t       op_r, op_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         neg_r, neg_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  x_r, x_nxt;
  logic [63:0]  d_r, d_nxt;
  logic [64:0]  rem_r, rem_nxt;
  logic         over_r, over_nxt;
  logic         done_r, done_nxt;
  logic [63:0]  y_r, y_nxt;

  logic [63:0] ma, mb, sum, dif, mag;
  logic [64:0] rsh, rsub;
  logic        ovf;

  assign ma  = a[63] ? (64'd0 - a) : a;
  assign mb  = b[63] ? (64'd0 - b) : b;
  assign sum = a + b;
  assign dif = a - b;
  assign rsh = {rem_r[63:0], x_r[63]};
  assign rsub = rsh - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r; op_nxt = op_r; cnt_nxt = cnt_r; neg_nxt = neg_r;
    acc_nxt = acc_r; x_nxt = x_r; d_nxt = d_r; rem_nxt = rem_r;
    over_nxt = over_r; done_nxt = 1'b0; y_nxt = y_r;
    mag = 64'd0; ovf = 1'b0;
    if (!busy_r && req.start) begin
      op_nxt = req.op;
      neg_nxt = a[63] ^ b[63];
      unique case (req.op)
        AU_ADD: begin
          y_nxt = sum;
          if (!(a[63] ^ b[63]) && (sum[63] ^ a[63])) y_nxt = a[63] ? SIGN_BIT : POS_MAX;
          done_nxt = 1'b1;
        end
        AU_SUB: begin
          y_nxt = dif;
          if ((a[63] ^ b[63]) && (dif[63] ^ a[63])) y_nxt = a[63] ? SIGN_BIT : POS_MAX;
          done_nxt = 1'b1;
        end
        AU_MUL: begin
          busy_nxt = 1'b1; cnt_nxt = 7'd64; acc_nxt = '0; x_nxt = ma; d_nxt = mb;
        end
        AU_DIV: begin
          // dividend is |a| << 32 as 128 bits; top 32 bits always zero,
          // so 96 steps cover it, zeros shifting in for the low 32
          busy_nxt = 1'b1; cnt_nxt = 7'd96; x_nxt = ma;
          rem_nxt = '0; d_nxt = mb; acc_nxt = '0; over_nxt = 1'b0;
        end
        default: ;
      endcase
    end else if (busy_r) begin
      if (cnt_r != 7'd0) begin
        cnt_nxt = cnt_r - 7'd1;
        if (op_r == AU_MUL) begin
          acc_nxt = {acc_r[126:0], 1'b0} + (x_r[63] ? {64'd0, d_r} : 128'd0);
          x_nxt = {x_r[62:0], 1'b0};
        end else begin
          x_nxt = {x_r[62:0], 1'b0};
          if (!rsub[64]) begin
            rem_nxt = rsub;
            if (cnt_r > 7'd64) over_nxt = 1'b1;
            acc_nxt = {acc_r[126:0], 1'b1};
          end else begin
            rem_nxt = rsh;
            acc_nxt = {acc_r[126:0], 1'b0};
          end
        end
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (op_r == AU_MUL) begin
          ovf = acc_r[127:96] != 32'd0;
          mag = acc_r[95:32];
        end else begin
          ovf = over_r;
          mag = acc_r[63:0];
        end
        if (neg_r) y_nxt = (ovf || mag > SIGN_BIT) ? SIGN_BIT : (64'd0 - mag);
        else y_nxt = (ovf || mag > POS_MAX) ? POS_MAX : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    op_r <= op_nxt; cnt_r <= cnt_nxt; neg_r <= neg_nxt; acc_r <= acc_nxt;
    x_r <= x_nxt; d_r <= d_nxt; rem_r <= rem_nxt; over_r <= over_nxt; y_r <= y_nxt;
  end

  assign done = done_r;
  assign y = y_r;

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r || $past(req.start)) else $error("done held");
  a_busy_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r != 7'd0 |=> !done_r) else $error("done during iteration");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= 7'd96) else $error("count out of range");
`endif
endmodule
